// File: hw/rtl/gmlb_pkg.sv
// Shared types and constants for the greedy least-loaded bucket assigner.
package gmlb_pkg;

  localparam int unsigned MAX_BUCKETS_DEF = 16;
  localparam int unsigned MAX_SLOTS_DEF   = 65536;

  localparam int unsigned ID_W         = 32;
  localparam int unsigned WEIGHT_W     = 16;
  localparam int unsigned LOAD_W       = 32;
  localparam int unsigned SLOT_OUT_W   = 16;
  localparam int unsigned BUCKET_OUT_W = 4;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned ROWS_W       = 5;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CFG_W-1:0]  BUCKET_COUNT_RST = 5'd4;
  localparam logic [ROWS_W-1:0] ROWS_MAX         = 5'd31;

  // register index (paddr[2])
  localparam logic REG_BUCKET_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

// File: hw/rtl/gmlb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gmlb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/greedy_min_load_bucket_assign_core.sv
// Greedy least-loaded bucket assigner: one input transfer places one weighted row into a
// bucket and gives one output transfer with the row id, bucket, slot and the bucket's new
// load. Within a job the first rows go to buckets 0, 1, 2, ... one each; later rows go to
// the bucket with the smallest load (lowest index on a tie). in_first_row starts a new job.
// Loads and slot counts live in one RAM with a registered read port; a per-bucket valid
// flop makes a never-written or cleared entry read as zero, so a new job needs no RAM clear.
// Sequence: a row placed directly passes through FETCH, WRITE and DONE before its result
// reaches the output register; a searched row first passes through SCAN, the minimum search
// that walks the RAM one bucket per cycle through a single 32-bit comparator. The block is
// busy (in_stall high) until the result is loaded, so a new row is not accepted before the
// last one is through; a finished result waits in the output register while the next row is
// accepted, and a result still held there stalls the following one in its last state.
// bucket_count is written over the APB-style port at any paddr with bit 2 clear and is read
// back there; a value of 0 acts as 1 and values above MAX_BUCKETS act as MAX_BUCKETS.
module greedy_min_load_bucket_assign_core
  import gmlb_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int unsigned MAX_SLOTS   = MAX_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,

  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_first_row,
  input  logic [ID_W-1:0]         in_row_id,
  input  logic [WEIGHT_W-1:0]     in_row_weight,

  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ID_W-1:0]         out_row_id_out,
  output logic [BUCKET_OUT_W-1:0] out_bucket,
  output logic [SLOT_OUT_W-1:0]   out_slot,
  output logic [LOAD_W-1:0]       out_bucket_load,

  // configuration port
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [PADDR_W-1:0]      cfg_paddr,
  input  logic [PDATA_W-1:0]      cfg_pwdata,
  output logic [PDATA_W-1:0]      cfg_prdata,
  output logic                    cfg_pready
);

  // bucket index and counter widths
  localparam int unsigned IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BUCKETS + 1);
  // slot counts saturate at min(MAX_SLOTS-1, 65535)
  localparam int unsigned SLOT_LIM = ((MAX_SLOTS - 1) > 65535) ? 65535 : (MAX_SLOTS - 1);
  localparam int unsigned SLOT_W   = $clog2(SLOT_LIM + 1);
  localparam int unsigned ENTRY_W  = LOAD_W + SLOT_W;

  // ---------------------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        bucket_count_r;
  logic [ROWS_W-1:0]       rows_seen_r, rows_seen_nxt;
  logic [MAX_BUCKETS-1:0]  valid_r, valid_nxt;
  logic [CNT_W-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic [IDX_W-1:0]        pick_r, pick_nxt;
  logic [LOAD_W-1:0]       min_r, min_nxt;
  logic [ID_W-1:0]         id_r, id_nxt;
  logic [WEIGHT_W-1:0]     weight_r, weight_nxt;
  logic [LOAD_W-1:0]       res_load_r, res_load_nxt;
  logic [SLOT_W-1:0]       res_slot_r, res_slot_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]         out_id_r, out_id_nxt;
  logic [BUCKET_OUT_W-1:0] out_bucket_r, out_bucket_nxt;
  logic [SLOT_OUT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [LOAD_W-1:0]       out_load_r, out_load_nxt;

  // ---------------------------------------------------------------------------------------
  // combinational signals
  // ---------------------------------------------------------------------------------------
  logic                    in_xfer;
  logic                    out_free;
  logic                    cfg_wr;
  logic [CNT_W-1:0]        act_n;
  logic [ROWS_W-1:0]       rows_eff;
  logic                    direct;
  logic                    scan_last;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic [LOAD_W-1:0]       rd_load;
  logic [SLOT_W-1:0]       rd_slot;

  logic [IDX_W-1:0]        cmp_idx;
  logic [LOAD_W-1:0]       cmp_load;
  logic [LOAD_W-1:0]       cur_load;
  logic [SLOT_W-1:0]       cur_slot;
  logic [LOAD_W:0]         sum_ext;
  logic [LOAD_W-1:0]       new_load;
  logic [SLOT_W-1:0]       new_slot;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // clamp the configured count to 1..MAX_BUCKETS
  always_comb begin
    if (bucket_count_r == '0) begin
      act_n = CNT_W'(1);
    end else if (32'(bucket_count_r) > MAX_BUCKETS) begin
      act_n = CNT_W'(MAX_BUCKETS);
    end else begin
      act_n = CNT_W'(bucket_count_r);
    end
  end

  // a first row restarts the job before it is placed
  assign rows_eff  = in_first_row ? '0 : rows_seen_r;
  assign direct    = 32'(rows_eff) < 32'(act_n);
  assign scan_last = 32'(scan_cnt_r) >= 32'(act_n);

  // RAM entry: {slot count, load}; an entry without its valid bit reads as zero
  assign rd_load = ram_rdata[LOAD_W-1:0];
  assign rd_slot = ram_rdata[ENTRY_W-1:LOAD_W];

  // scan: data on the read port belongs to the address issued in the cycle before
  assign cmp_idx  = IDX_W'(scan_cnt_r - CNT_W'(1));
  assign cmp_load = valid_r[cmp_idx] ? rd_load : '0;

  // update of the picked bucket, saturating
  assign cur_load  = valid_r[pick_r] ? rd_load : '0;
  assign cur_slot  = valid_r[pick_r] ? rd_slot : '0;
  assign sum_ext   = {1'b0, cur_load} + (LOAD_W + 1)'(weight_r);
  assign new_load  = sum_ext[LOAD_W] ? '1 : sum_ext[LOAD_W-1:0];
  assign new_slot  = (cur_slot < SLOT_W'(SLOT_LIM)) ? cur_slot + SLOT_W'(1) : cur_slot;
  assign ram_wdata = {new_slot, new_load};

  gmlb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = direct ? ST_FETCH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_raddr = pick_r;
    case (state_r)
      ST_IDLE:  in_stall  = 1'b0;
      ST_SCAN:  ram_raddr = IDX_W'(scan_cnt_r);
      ST_FETCH: ram_raddr = pick_r;
      ST_WRITE: ram_we    = 1'b1;
      ST_DONE:  ram_we    = 1'b0;
      default:  in_stall  = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // datapath next values
  // ---------------------------------------------------------------------------------------
  always_comb begin
    rows_seen_nxt  = rows_seen_r;
    valid_nxt      = valid_r;
    scan_cnt_nxt   = scan_cnt_r;
    pick_nxt       = pick_r;
    min_nxt        = min_r;
    id_nxt         = id_r;
    weight_nxt     = weight_r;
    res_load_nxt   = res_load_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_id_nxt     = out_id_r;
    out_bucket_nxt = out_bucket_r;
    out_slot_nxt   = out_slot_r;
    out_load_nxt   = out_load_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          id_nxt       = in_row_id;
          weight_nxt   = in_row_weight;
          scan_cnt_nxt = '0;
          pick_nxt     = IDX_W'(rows_eff);
          if (in_first_row) begin
            valid_nxt     = '0;
            rows_seen_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (!scan_last) begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end
        if (scan_cnt_r != '0) begin
          // strict less-than keeps the lowest index on a tie
          if (scan_cnt_r == CNT_W'(1) || cmp_load < min_r) begin
            min_nxt  = cmp_load;
            pick_nxt = cmp_idx;
          end
        end
      end
      ST_WRITE: begin
        valid_nxt[pick_r] = 1'b1;
        res_load_nxt      = new_load;
        res_slot_nxt      = cur_slot;
        if (rows_seen_r != ROWS_MAX) begin
          rows_seen_nxt = rows_seen_r + ROWS_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = id_r;
          out_bucket_nxt = BUCKET_OUT_W'(pick_r);
          out_slot_nxt   = SLOT_OUT_W'(res_slot_r);
          out_load_nxt   = res_load_r;
        end
      end
      default: begin
        scan_cnt_nxt = scan_cnt_r;
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // state registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      bucket_count_r <= BUCKET_COUNT_RST;
      rows_seen_r    <= '0;
      valid_r        <= '0;
      scan_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_seen_r <= rows_seen_nxt;
      valid_r     <= valid_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_BUCKET_COUNT) begin
        bucket_count_r <= cfg_pwdata[CFG_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pick_r       <= pick_nxt;
    min_r        <= min_nxt;
    id_r         <= id_nxt;
    weight_r     <= weight_nxt;
    res_load_r   <= res_load_nxt;
    res_slot_r   <= res_slot_nxt;
    out_id_r     <= out_id_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_slot_r   <= out_slot_nxt;
    out_load_r   <= out_load_nxt;
  end

  // ---------------------------------------------------------------------------------------
  // ports
  // ---------------------------------------------------------------------------------------
  assign out_valid       = out_valid_r;
  assign out_row_id_out  = out_id_r;
  assign out_bucket      = out_bucket_r;
  assign out_slot        = out_slot_r;
  assign out_bucket_load = out_load_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_BUCKET_COUNT) ? PDATA_W'(bucket_count_r) : '0;

`ifndef SYNTH
  // a new job leaves no stale bucket entries behind
  a_first_row_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_first_row) |=> (valid_r == '0))
    else $error("first row did not clear bucket valid bits");

  // a result only appears after the sequencer finished an item
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside of completion");

  // the written bucket reads back as valid
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> valid_r[$past(pick_r)])
    else $error("bucket update did not mark entry valid");
`endif

endmodule
